// File: hdl/zzs_pkg.sv
`timescale 1ns / 1ps

package zzs_pkg;

   localparam int MAX_SIDE = 8;
   localparam int COORD_W  = 3;
   localparam int ADDR_W   = 2 * COORD_W;
   localparam int CELLS    = MAX_SIDE * MAX_SIDE;
   localparam int BYTE_W   = 8;
   localparam int SIZE_W   = 4;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PERMUTE,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP
   } spiral_dir_type;

   typedef struct packed {
      logic start;
      logic step;
   } walk_ctrl_type;

endpackage

// File: hdl/zzs_ram.sv
`timescale 1ns / 1ps

module zzs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/zzs_zigzag_walk.sv
`timescale 1ns / 1ps

module zzs_zigzag_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  zzs_pkg::walk_ctrl_type ctrl,
   input  zzs_pkg::coord_type     last_idx,
   output zzs_pkg::coord_type     row,
   output zzs_pkg::coord_type     col
);

   zzs_pkg::coord_type row_ff, row_in;
   zzs_pkg::coord_type col_ff, col_in;
   logic               up_ff, up_in;

   logic signed [4:0] r_cur, c_cur, r_step, c_step, r_new, c_new, lim;
   logic              up_new;

   always_comb begin
      r_cur  = signed'({2'b00, row_ff});
      c_cur  = signed'({2'b00, col_ff});
      lim    = signed'({2'b00, last_idx});
      r_step = up_ff ? r_cur - 5'sd1 : r_cur + 5'sd1;
      c_step = up_ff ? c_cur + 5'sd1 : c_cur - 5'sd1;
      r_new  = r_step;
      c_new  = c_step;
      up_new = up_ff;
      if (c_step > lim) begin
         c_new  = lim;
         r_new  = r_step + 5'sd2;
         up_new = ~up_ff;
      end else if (r_step > lim) begin
         r_new  = lim;
         c_new  = c_step + 5'sd2;
         up_new = ~up_ff;
      end else if (r_step < 5'sd0) begin
         r_new  = 5'sd0;
         up_new = ~up_ff;
      end else if (c_step < 5'sd0) begin
         c_new  = 5'sd0;
         up_new = ~up_ff;
      end

      row_in = row_ff;
      col_in = col_ff;
      up_in  = up_ff;
      if (ctrl.start) begin
         row_in = '0;
         col_in = '0;
         up_in  = 1'b1;
      end else if (ctrl.step) begin
         row_in = r_new[zzs_pkg::COORD_W-1:0];
         col_in = c_new[zzs_pkg::COORD_W-1:0];
         up_in  = up_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         up_ff  <= 1'b1;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         up_ff  <= up_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;

endmodule

// File: hdl/zzs_spiral_walk.sv
`timescale 1ns / 1ps

module zzs_spiral_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  zzs_pkg::walk_ctrl_type ctrl,
   input  zzs_pkg::coord_type     last_idx,
   output zzs_pkg::coord_type     row,
   output zzs_pkg::coord_type     col
);

   zzs_pkg::coord_type      row_ff, row_in;
   zzs_pkg::coord_type      col_ff, col_in;
   zzs_pkg::coord_type      top_ff, top_in;
   zzs_pkg::coord_type      bot_ff, bot_in;
   zzs_pkg::coord_type      lft_ff, lft_in;
   zzs_pkg::coord_type      rgt_ff, rgt_in;
   zzs_pkg::spiral_dir_type dir_ff, dir_in;

   // The four bounds close in on the cells already walked, so a turn happens
   // exactly where the next cell would be outside the block or already visited.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      top_in = top_ff;
      bot_in = bot_ff;
      lft_in = lft_ff;
      rgt_in = rgt_ff;
      dir_in = dir_ff;
      if (ctrl.start) begin
         row_in = '0;
         col_in = '0;
         top_in = '0;
         lft_in = '0;
         bot_in = last_idx;
         rgt_in = last_idx;
         dir_in = zzs_pkg::DIR_RIGHT;
      end else if (ctrl.step) begin
         unique case (dir_ff)
            zzs_pkg::DIR_RIGHT: begin
               if (col_ff < rgt_ff) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  dir_in = zzs_pkg::DIR_DOWN;
                  top_in = top_ff + 1'b1;
                  row_in = row_ff + 1'b1;
               end
            end
            zzs_pkg::DIR_DOWN: begin
               if (row_ff < bot_ff) begin
                  row_in = row_ff + 1'b1;
               end else begin
                  dir_in = zzs_pkg::DIR_LEFT;
                  rgt_in = rgt_ff - 1'b1;
                  col_in = col_ff - 1'b1;
               end
            end
            zzs_pkg::DIR_LEFT: begin
               if (col_ff > lft_ff) begin
                  col_in = col_ff - 1'b1;
               end else begin
                  dir_in = zzs_pkg::DIR_UP;
                  bot_in = bot_ff - 1'b1;
                  row_in = row_ff - 1'b1;
               end
            end
            zzs_pkg::DIR_UP: begin
               if (row_ff > top_ff) begin
                  row_in = row_ff - 1'b1;
               end else begin
                  dir_in = zzs_pkg::DIR_RIGHT;
                  lft_in = lft_ff + 1'b1;
                  col_in = col_ff + 1'b1;
               end
            end
            default: begin
               dir_in = zzs_pkg::DIR_RIGHT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         top_ff <= '0;
         bot_ff <= '0;
         lft_ff <= '0;
         rgt_ff <= '0;
         dir_ff <= zzs_pkg::DIR_RIGHT;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         top_ff <= top_in;
         bot_ff <= bot_in;
         lft_ff <= lft_in;
         rgt_ff <= rgt_in;
         dir_ff <= dir_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;

endmodule

// File: hdl/zigzag_to_spiral_reorder.sv
`timescale 1ns / 1ps

// Reorders a square block of n by n bytes, n set by csr_block_size (0 acts as 1, above 8 acts
// as 8). Bytes enter row-major at one item per cycle while req_ready is high. After the last
// byte of a block, a permute pass steps a zigzag walker and a clockwise spiral walker
// together, one cell per cycle through the single read port of the load buffer, and writes
// each byte to its spiral cell in a second buffer. The block then emits n*n items in
// row-major order at one per cycle while the receiver is ready, with row_end on each row's
// last cell and block_last on the final one. req_ready is low from the end of a load until
// the last item of the emit phase has moved into the output register and the block is back
// in its load state. A write to the size register drops any partly loaded block, and while
// a size write is offered the input is held off.
module zigzag_to_spiral_reorder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_cell_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_row_end,
   output logic       rsp_block_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_block_size
);

   zzs_pkg::state_type           state_ff, state_in;
   logic [zzs_pkg::SIZE_W-1:0]   block_size_ff, block_size_in;
   zzs_pkg::coord_type           load_row_ff, load_row_in;
   zzs_pkg::coord_type           load_col_ff, load_col_in;
   zzs_pkg::coord_type           em_row_ff, em_row_in;
   zzs_pkg::coord_type           em_col_ff, em_col_in;
   logic                         em_more_ff, em_more_in;
   logic                         wr_pend_ff, wr_pend_in;
   zzs_pkg::addr_type            wr_addr_ff, wr_addr_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic                         rd_row_end_ff, rd_row_end_in;
   logic                         rd_last_ff, rd_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [zzs_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                         rsp_row_end_ff, rsp_row_end_in;
   logic                         rsp_last_ff, rsp_last_in;

   zzs_pkg::coord_type           last_idx;
   zzs_pkg::coord_type           zig_row, zig_col, sp_row, sp_col;
   zzs_pkg::walk_ctrl_type       walk_ctrl;
   logic                         req_take, csr_take, load_done, perm_done;
   logic                         take, issue;
   logic [zzs_pkg::BYTE_W-1:0]   store_rdata, grid_rdata;

   always_comb begin
      if (block_size_ff == '0) begin
         last_idx = '0;
      end else if (block_size_ff > zzs_pkg::SIZE_W'(zzs_pkg::MAX_SIDE)) begin
         last_idx = zzs_pkg::COORD_W'(zzs_pkg::MAX_SIDE - 1);
      end else begin
         last_idx = zzs_pkg::COORD_W'(block_size_ff - 1'b1);
      end
   end

   assign req_ready = (state_ff == zzs_pkg::ST_LOAD) && !csr_valid;
   assign csr_ready = (state_ff == zzs_pkg::ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign csr_take  = csr_valid && csr_ready;
   assign load_done = req_take && (load_row_ff == last_idx) && (load_col_ff == last_idx);
   assign perm_done = (zig_row == last_idx) && (zig_col == last_idx);
   assign take      = rd_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue     = (state_ff == zzs_pkg::ST_EMIT) && em_more_ff && (!rd_pend_ff || take);

   assign walk_ctrl.start = load_done;
   assign walk_ctrl.step  = (state_ff == zzs_pkg::ST_PERMUTE);

   zzs_zigzag_walk u_zig (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (walk_ctrl),
      .last_idx (last_idx),
      .row      (zig_row),
      .col      (zig_col)
   );

   zzs_spiral_walk u_spiral (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (walk_ctrl),
      .last_idx (last_idx),
      .row      (sp_row),
      .col      (sp_col)
   );

   zzs_ram #(
      .WIDTH (zzs_pkg::BYTE_W),
      .DEPTH (zzs_pkg::CELLS)
   ) u_store (
      .clock (clock),
      .we    (req_take),
      .waddr ({load_row_ff, load_col_ff}),
      .wdata (req_cell_byte),
      .re    (walk_ctrl.step),
      .raddr ({zig_row, zig_col}),
      .rdata (store_rdata)
   );

   zzs_ram #(
      .WIDTH (zzs_pkg::BYTE_W),
      .DEPTH (zzs_pkg::CELLS)
   ) u_grid (
      .clock (clock),
      .we    (wr_pend_ff),
      .waddr (wr_addr_ff),
      .wdata (store_rdata),
      .re    (issue),
      .raddr ({em_row_ff, em_col_ff}),
      .rdata (grid_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      block_size_in  = block_size_ff;
      load_row_in    = load_row_ff;
      load_col_in    = load_col_ff;
      em_row_in      = em_row_ff;
      em_col_in      = em_col_ff;
      em_more_in     = em_more_ff;
      wr_pend_in     = walk_ctrl.step;
      wr_addr_in     = {sp_row, sp_col};
      rd_pend_in     = rd_pend_ff;
      rd_row_end_in  = rd_row_end_ff;
      rd_last_in     = rd_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_row_end_in = rsp_row_end_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_take) begin
         block_size_in = csr_block_size;
         load_row_in   = '0;
         load_col_in   = '0;
      end else if (req_take) begin
         if (load_col_ff == last_idx) begin
            load_col_in = '0;
            load_row_in = (load_row_ff == last_idx) ? '0 : load_row_ff + 1'b1;
         end else begin
            load_col_in = load_col_ff + 1'b1;
         end
      end

      unique case (state_ff)
         zzs_pkg::ST_LOAD: begin
            if (load_done) begin
               state_in = zzs_pkg::ST_PERMUTE;
            end
         end
         zzs_pkg::ST_PERMUTE: begin
            if (perm_done) begin
               state_in = zzs_pkg::ST_FLUSH;
            end
         end
         zzs_pkg::ST_FLUSH: begin
            state_in   = zzs_pkg::ST_EMIT;
            em_row_in  = '0;
            em_col_in  = '0;
            em_more_in = 1'b1;
         end
         zzs_pkg::ST_EMIT: begin
            if (!em_more_ff && !rd_pend_ff) begin
               state_in = zzs_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = zzs_pkg::ST_LOAD;
         end
      endcase

      if (issue) begin
         rd_row_end_in = (em_col_ff == last_idx);
         rd_last_in    = (em_col_ff == last_idx) && (em_row_ff == last_idx);
         if (em_col_ff == last_idx) begin
            em_col_in = '0;
            if (em_row_ff == last_idx) begin
               em_more_in = 1'b0;
            end else begin
               em_row_in = em_row_ff + 1'b1;
            end
         end else begin
            em_col_in = em_col_ff + 1'b1;
         end
      end

      if (issue) begin
         rd_pend_in = 1'b1;
      end else if (take) begin
         rd_pend_in = 1'b0;
      end

      if (take) begin
         rsp_valid_in   = 1'b1;
         rsp_byte_in    = grid_rdata;
         rsp_row_end_in = rd_row_end_ff;
         rsp_last_in    = rd_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= zzs_pkg::ST_LOAD;
         block_size_ff <= zzs_pkg::SIZE_W'(zzs_pkg::MAX_SIDE);
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         em_more_ff    <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         block_size_ff <= block_size_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         em_more_ff    <= em_more_in;
         wr_pend_ff    <= wr_pend_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      em_row_ff      <= em_row_in;
      em_col_ff      <= em_col_in;
      wr_addr_ff     <= wr_addr_in;
      rd_row_end_ff  <= rd_row_end_in;
      rd_last_ff     <= rd_last_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_row_end_ff <= rsp_row_end_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_block_last = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_last |-> rsp_row_end)
      else $error("Final item of a block is not marked as a row end.");

   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff && !take |=> rd_pend_ff && $stable(grid_rdata))
      else $error("Pending read data was lost before it reached the output register.");

   assert property (@(posedge clock) disable iff (reset)
      csr_take |=> load_row_ff == '0 && load_col_ff == '0)
      else $error("Size write did not drop the partly loaded block.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == zzs_pkg::ST_PERMUTE && perm_done |=> wr_pend_ff && !req_ready)
      else $error("Last permute write was not completed before the emit phase.");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SETTLE_CYCLES = 3 * zzs_pkg::CELLS + 2;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int PRINT_LIMIT   = 50;
   localparam int ITEM_TARGET   = 320;
   localparam logic [zzs_pkg::BYTE_W-1:0] AT_SIGN   = 8'h40;
   localparam logic [zzs_pkg::BYTE_W-1:0] BANG_SIGN = 8'h21;

   typedef struct packed {
      logic [zzs_pkg::BYTE_W-1:0] value;
      logic                       row_end;
      logic                       block_last;
   } cell_result_type;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [zzs_pkg::BYTE_W-1:0] req_cell_byte  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic [zzs_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                       rsp_row_end;
   logic                       rsp_block_last;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [zzs_pkg::SIZE_W-1:0] csr_block_size = '0;

   logic [zzs_pkg::BYTE_W-1:0] loaded_cells [zzs_pkg::CELLS];
   int                         loaded         = 0;
   logic [zzs_pkg::SIZE_W-1:0] size_reg       = 4'd8;
   cell_result_type            reordered_q [$];

   int mismatches    = 0;
   int cells_sent    = 0;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;

   zigzag_to_spiral_reorder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_byte  (req_cell_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_block_last (rsp_block_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_block_size (csr_block_size)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int side_of(input logic [zzs_pkg::SIZE_W-1:0] value);
      if (value == 0) return 1;
      if (value > zzs_pkg::MAX_SIDE) return zzs_pkg::MAX_SIDE;
      return int'(value);
   endfunction

   function automatic int row_step(input zzs_pkg::spiral_dir_type dir);
      case (dir)
         zzs_pkg::DIR_DOWN: return 1;
         zzs_pkg::DIR_UP:   return -1;
         default:           return 0;
      endcase
   endfunction

   function automatic int col_step(input zzs_pkg::spiral_dir_type dir);
      case (dir)
         zzs_pkg::DIR_RIGHT: return 1;
         zzs_pkg::DIR_LEFT:  return -1;
         default:            return 0;
      endcase
   endfunction

   // The k-th cell of the zigzag scan lands on the k-th cell of the spiral.
   function automatic void reorder_block(input int n);
      zzs_pkg::addr_type          zig [zzs_pkg::CELLS];
      zzs_pkg::addr_type          spi [zzs_pkg::CELLS];
      logic                       seen [zzs_pkg::CELLS];
      logic [zzs_pkg::BYTE_W-1:0] grid [zzs_pkg::CELLS];
      int                         r, c, d, k, nr, nc;
      zzs_pkg::spiral_dir_type    dir;
      cell_result_type            res;
      r = 0;
      c = 0;
      d = 1;
      for (k = 0; k < n * n; k++) begin
         zig[k] = zzs_pkg::addr_type'(r * n + c);
         r = r - d;
         c = c + d;
         if (c > n - 1) begin
            c = n - 1;
            r = r + 2;
            d = -d;
         end else if (r > n - 1) begin
            r = n - 1;
            c = c + 2;
            d = -d;
         end else if (r < 0) begin
            r = 0;
            d = -d;
         end else if (c < 0) begin
            c = 0;
            d = -d;
         end
      end
      for (k = 0; k < zzs_pkg::CELLS; k++) seen[k] = 1'b0;
      r = 0;
      c = 0;
      dir = zzs_pkg::DIR_RIGHT;
      for (k = 0; k < n * n; k++) begin
         spi[k] = zzs_pkg::addr_type'(r * n + c);
         seen[r * n + c] = 1'b1;
         if (k < n * n - 1) begin
            nr = r + row_step(dir);
            nc = c + col_step(dir);
            if (nr < 0 || nr >= n || nc < 0 || nc >= n || seen[nr * n + nc]) begin
               dir = dir.next();
               nr = r + row_step(dir);
               nc = c + col_step(dir);
            end
            r = nr;
            c = nc;
         end
      end
      for (k = 0; k < n * n; k++) grid[spi[k]] = loaded_cells[zig[k]];
      for (k = 0; k < n * n; k++) begin
         res.value      = grid[k];
         res.row_end    = (k % n == n - 1);
         res.block_last = (k == n * n - 1);
         reordered_q.push_back(res);
      end
   endfunction

   function automatic void load_cell(input logic [zzs_pkg::BYTE_W-1:0] value);
      int n;
      n = side_of(size_reg);
      if (loaded >= n * n) loaded = 0;
      loaded_cells[loaded] = value;
      loaded++;
      if (loaded == n * n) begin
         loaded = 0;
         reorder_block(n);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_result;
      cell_result_type want;
      if (reordered_q.size() == 0) begin
         report_mismatch($sformatf("item out_byte=%02h with none expected", rsp_out_byte));
      end else begin
         want = reordered_q.pop_front();
         if (rsp_out_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", rsp_out_byte,
                                      want.value));
         if (rsp_row_end !== want.row_end)
            report_mismatch($sformatf("row_end %b, expected %b", rsp_row_end, want.row_end));
         if (rsp_block_last !== want.block_last)
            report_mismatch($sformatf("block_last %b, expected %b", rsp_block_last,
                                      want.block_last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
      if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_cell(input logic [zzs_pkg::BYTE_W-1:0] value);
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      load_cell(value);
      cells_sent++;
   endtask

   task automatic send_random_cells(input int count);
      repeat (count) send_cell(8'($urandom_range(0, 255)));
   endtask

   task automatic write_block_size(input logic [zzs_pkg::SIZE_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_block_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_reg = value;
      loaded   = 0;
   endtask

   // The size register may only change once the block has gone quiet.
   task automatic settle_block;
      req_valid <= 1'b0;
      while (reordered_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_idling;
      int choice;
      choice = $urandom_range(2);
      req_gap_pct   = (choice == 0) ? 0 : (choice == 1) ? 20 : 50;
      choice = $urandom_range(2);
      rsp_stall_pct <= (choice == 0) ? 0 : (choice == 1) ? 20 : 50;
   endtask

   task automatic test_default_size;
      pick_idling();
      send_random_cells(zzs_pkg::CELLS);
   endtask

   task automatic test_single_cell;
      settle_block();
      write_block_size(4'd1);
      send_cell(8'h00);
      send_cell(8'hFF);
      send_cell(AT_SIGN);
      settle_block();
      write_block_size(4'd0);
      send_cell(8'hA5);
   endtask

   task automatic test_sentinel_bytes;
      settle_block();
      write_block_size(4'd2);
      send_cell(AT_SIGN);
      send_cell(BANG_SIGN);
      send_cell(AT_SIGN);
      send_cell(AT_SIGN);
   endtask

   task automatic test_dropped_partial;
      settle_block();
      write_block_size(4'd3);
      send_random_cells(5);
      settle_block();
      write_block_size(4'd3);
      send_random_cells(9);
   endtask

   task automatic test_backpressure;
      settle_block();
      write_block_size(4'd4);
      req_gap_pct = 0;
      holds_asked <= holds_asked + 1;
      send_random_cells(48);
   endtask

   task automatic test_random_sizes;
      int                         pick;
      int                         n;
      logic [zzs_pkg::SIZE_W-1:0] value;
      while (cells_sent < ITEM_TARGET - 2 * zzs_pkg::CELLS) begin
         pick = $urandom_range(99);
         if (pick < 55) value = 4'($urandom_range(1, 4));
         else if (pick < 80) value = 4'($urandom_range(5, 7));
         else if (pick < 88) value = 4'd8;
         else value = 4'($urandom_range(9, 16));
         settle_block();
         pick_idling();
         write_block_size(value);
         n = side_of(value);
         if (n > 1 && $urandom_range(4) == 0) begin
            send_random_cells($urandom_range(1, n * n - 1));
            settle_block();
            write_block_size(value);
         end
         send_random_cells($urandom_range(1, 3) * n * n);
      end
   endtask

   task automatic test_steady_stream;
      settle_block();
      req_gap_pct = 0;
      rsp_stall_pct <= 0;
      write_block_size(4'd15);
      send_random_cells(zzs_pkg::CELLS);
      send_random_cells(zzs_pkg::CELLS);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_size();
      test_single_cell();
      test_sentinel_bytes();
      test_dropped_partial();
      test_backpressure();
      test_random_sizes();
      test_steady_stream();
      settle_block();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/zzs_pkg.sv
hdl/zzs_ram.sv
hdl/zzs_zigzag_walk.sv
hdl/zzs_spiral_walk.sv
hdl/zigzag_to_spiral_reorder.sv
dv/testbench.sv
